// ===== rtl/tct_pkg.sv =====
// Shared constants and types for the terminal cursor tracker.
package tct_pkg;

   localparam int COORD_BITS_DEFAULT = 8;

   localparam int CHAR_BITS      = 8;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 8;
   localparam int TAB_BITS       = 5;
   localparam int MODE_BITS      = 2;

   localparam logic [CHAR_BITS-1:0] CHR_BS       = 8'd8;
   localparam logic [CHAR_BITS-1:0] CHR_TAB      = 8'd9;
   localparam logic [CHAR_BITS-1:0] CHR_LF       = 8'd10;
   localparam logic [CHAR_BITS-1:0] CHR_FF       = 8'd12;
   localparam logic [CHAR_BITS-1:0] CHR_CR       = 8'd13;
   localparam logic [CHAR_BITS-1:0] CHR_PRINT_LO = 8'd32;
   localparam logic [CHAR_BITS-1:0] CHR_PRINT_HI = 8'd126;

   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_COLUMNS      = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_ROWS         = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TAB_WIDTH        = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LINE_ENDING_MODE = 8'd3;

   localparam logic [MODE_BITS-1:0] MODE_LF   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_CR   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_CRLF = 2'd2;

   localparam logic [7:0]           RST_MAX_COLUMNS = 8'd80;
   localparam logic [7:0]           RST_MAX_ROWS    = 8'd24;
   localparam logic [TAB_BITS-1:0]  RST_TAB_WIDTH   = 5'd8;
   localparam logic [MODE_BITS-1:0] RST_MODE        = MODE_CRLF;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture item, seed divider
      logic div_step;  // one restoring-divide step
      logic mul;       // quotient times tab width
      logic commit;    // update cursor, load output register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_tab;    // item on req_tdata is a tab
   } dp_status_type;

endpackage

// ===== rtl/tct_ctrl.sv =====
// Sequencer for the cursor tracker: handshakes, divide step count, output valid.
module tct_ctrl #(
   parameter int COORD_BITS = tct_pkg::COORD_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  tct_pkg::dp_status_type status,
   output tct_pkg::dp_cmd_type    cmd
);

   localparam int DIV_BITS = COORD_BITS + 1;
   localparam int CNT_BITS = $clog2(DIV_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_BITS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_COMMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = status.is_tab ? ST_DIV : ST_COMMIT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/tct_datapath.sv =====
// Cursor state, configuration registers, tab divider and output register.
module tct_datapath #(
   parameter int COORD_BITS = tct_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tct_pkg::dp_cmd_type                   cmd,
   output tct_pkg::dp_status_type                status,
   input  logic [tct_pkg::CHAR_BITS-1:0]         req_char,
   input  logic                                  csr_write,
   input  logic [tct_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tct_pkg::CSR_DATA_BITS-1:0]     csr_data,
   output logic [7:0]                            rsp_row,
   output logic [7:0]                            rsp_column
);

   localparam int DIV_BITS = COORD_BITS + 1;
   localparam int TB       = tct_pkg::TAB_BITS;

   logic [7:0]                      max_cols_ff;
   logic [7:0]                      max_rows_ff;
   logic [TB-1:0]                   tab_ff;
   logic [tct_pkg::MODE_BITS-1:0]   mode_ff;

   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [tct_pkg::CHAR_BITS-1:0] char_ff;
   logic [DIV_BITS-1:0]   div_ff;
   logic [TB-1:0]         rem_ff;
   logic [DIV_BITS-1:0]   tab_col_ff;
   logic [7:0]            out_row_ff, out_col_ff;

   logic [7:0]            cols_eff, rows_eff;
   logic [TB-1:0]         tab_eff;
   logic [TB:0]           trial;
   logic                  qbit;
   logic [DIV_BITS+TB-1:0] product;

   logic [COORD_BITS-1:0] dec_col;
   logic [DIV_BITS-1:0]   wrap_col;
   logic                  wrap_en;
   logic                  adv;

   assign cols_eff = (max_cols_ff == '0) ? 8'd1 : max_cols_ff;
   assign rows_eff = (max_rows_ff == '0) ? 8'd1 : max_rows_ff;
   assign tab_eff  = (tab_ff == '0) ? TB'(1) : tab_ff;

   assign status.is_tab = (req_char == tct_pkg::CHR_TAB);

   // restoring divide: remainder stays below the divisor
   assign trial   = {rem_ff, div_ff[DIV_BITS-1]};
   assign qbit    = (trial >= {1'b0, tab_eff});
   assign product = div_ff * tab_eff;

   assign dec_col = col_ff - 1'b1;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      wrap_en  = 1'b0;
      wrap_col = tab_col_ff;
      adv      = 1'b0;
      case (char_ff)
         tct_pkg::CHR_BS: begin
            if (dec_col == '0) begin
               col_in = COORD_BITS'(cols_eff);
               if (row_ff > COORD_BITS'(1)) begin
                  row_in = row_ff - 1'b1;
               end
            end else begin
               col_in = dec_col;
            end
         end
         tct_pkg::CHR_TAB: begin
            wrap_en  = 1'b1;
            wrap_col = tab_col_ff;
         end
         tct_pkg::CHR_LF: begin
            if (mode_ff != tct_pkg::MODE_CR) begin
               col_in = COORD_BITS'(1);
            end
            adv = 1'b1;
         end
         tct_pkg::CHR_FF: begin
            col_in = COORD_BITS'(1);
            row_in = COORD_BITS'(1);
         end
         tct_pkg::CHR_CR: begin
            col_in = COORD_BITS'(1);
            if (mode_ff != tct_pkg::MODE_LF) begin
               adv = 1'b1;
            end
         end
         default: begin
            if (char_ff inside {[tct_pkg::CHR_PRINT_LO:tct_pkg::CHR_PRINT_HI]}) begin
               wrap_en  = 1'b1;
               wrap_col = DIV_BITS'(col_ff) + 1'b1;
            end
         end
      endcase
      if (wrap_en) begin
         if (wrap_col >= DIV_BITS'(cols_eff)) begin
            col_in = COORD_BITS'(1);
            adv    = 1'b1;
         end else begin
            col_in = wrap_col[COORD_BITS-1:0];
         end
      end
      if (adv && (DIV_BITS'(row_ff) < DIV_BITS'(rows_eff))) begin
         row_in = row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_cols_ff <= tct_pkg::RST_MAX_COLUMNS;
         max_rows_ff <= tct_pkg::RST_MAX_ROWS;
         tab_ff      <= tct_pkg::RST_TAB_WIDTH;
         mode_ff     <= tct_pkg::RST_MODE;
         col_ff      <= COORD_BITS'(1);
         row_ff      <= COORD_BITS'(1);
      end else begin
         if (csr_write) begin
            case (csr_index)
               tct_pkg::REG_MAX_COLUMNS:      max_cols_ff <= csr_data;
               tct_pkg::REG_MAX_ROWS:         max_rows_ff <= csr_data;
               tct_pkg::REG_TAB_WIDTH:        tab_ff      <= csr_data[TB-1:0];
               tct_pkg::REG_LINE_ENDING_MODE: mode_ff <= csr_data[tct_pkg::MODE_BITS-1:0];
               default: ;
            endcase
         end
         if (cmd.commit) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         char_ff <= req_char;
         div_ff  <= DIV_BITS'(col_ff) + DIV_BITS'(tab_eff) - 1'b1;
         rem_ff  <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= qbit ? TB'(trial - {1'b0, tab_eff}) : trial[TB-1:0];
         div_ff <= {div_ff[DIV_BITS-2:0], qbit};
      end
      if (cmd.mul) begin
         tab_col_ff <= product[DIV_BITS-1:0];
      end
      if (cmd.commit) begin
         out_row_ff <= 8'(row_in);
         out_col_ff <= 8'(col_in);
      end
   end

   assign rsp_row    = out_row_ff;
   assign rsp_column = out_col_ff;

endmodule

// ===== rtl/terminal_cursor_tracker_top.sv =====
// Top level of the terminal cursor tracker.
// Each byte taken on req_ updates a 1-based cursor row and column and one item
// with both comes back on rsp_. One byte is in work at a time. A tab goes
// through the restoring divider, which rounds the column up to a multiple of
// the tab width one quotient bit per cycle, and then a multiply before the
// commit; every other byte goes straight to the commit. A new byte is taken
// while the last result still waits on rsp_, but its commit waits until rsp_
// is free. Configuration writes on csr_ are always taken (csr_ready is tied
// high) and belong in idle periods; indexes above 3 are ignored.
module terminal_cursor_tracker_top #(
   parameter int COORD_BITS = tct_pkg::COORD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: [7:0] char_code
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,
   // rsp_tdata: [7:0] cursor_row, [15:8] cursor_column
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tct_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tct_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   tct_pkg::dp_cmd_type    cmd;
   tct_pkg::dp_status_type status;
   logic [7:0]             row_out, col_out;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {col_out, row_out};

   tct_ctrl #(
      .COORD_BITS(COORD_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tct_datapath #(
      .COORD_BITS(COORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_char   (req_tdata),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_row    (row_out),
      .rsp_column (col_out)
   );

   // one byte in work at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after an accepted item");

   // a result only appears after the block stopped taking input
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("rsp_tvalid rose without an item in work");

   // no two of load, divide step, multiply and commit coincide
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.load, cmd.div_step, cmd.mul, cmd.commit}) <= 1)
      else $error("more than one datapath command at once");

endmodule
